@@ rtl/lfu_pkg.sv @@
`default_nettype none

package lfu_pkg;

    localparam int ADDR_W          = 32;
    localparam int OFFSET_W        = 6;
    localparam int WAY_W           = 4;
    localparam int TOTAL_W         = 32;
    localparam int CFG_W           = 3;
    localparam int CFG_RESET       = 2;
    localparam int MAX_OFFSET_BITS = 6;
    localparam int IN_DATA_W       = 32;
    localparam int OUT_DATA_W      = 80;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_W     = 1;

    typedef struct packed {
        logic [ADDR_W-1:0]   line;
        logic [OFFSET_W-1:0] offset;
    } lfu_req_t;

    typedef struct packed {
        logic [TOTAL_W-1:0]  miss_total;
        logic [TOTAL_W-1:0]  hit_total;
        logic                replaced_valid;
        logic [OFFSET_W-1:0] offset;
        logic [WAY_W-1:0]    way;
        logic                hit;
    } lfu_rsp_t;

    typedef enum logic {
        BACK_LOOKUP,
        BACK_UPDATE
    } lfu_back_state_t;

endpackage

`default_nettype wire

@@ rtl/lfu_front.sv @@
`default_nettype none

module lfu_front
    import lfu_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_DATA_W-1:0] s_tdata,
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output lfu_req_t                  push_req
);

    logic [CFG_W-1:0]  offset_bits_reg;
    logic [CFG_W-1:0]  offset_bits;
    logic [ADDR_W-1:0] low_mask;
    logic [ADDR_W-1:0] addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= CFG_W'(CFG_RESET);
        end
        else if (cfg_we)
        begin
            offset_bits_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        addr        = s_tdata[ADDR_W-1:0];
        offset_bits = (offset_bits_reg > CFG_W'(MAX_OFFSET_BITS)) ?
                      CFG_W'(MAX_OFFSET_BITS) : offset_bits_reg;
        low_mask    = ~({ADDR_W{1'b1}} << offset_bits);
        push_req.line   = addr & ~low_mask;
        push_req.offset = addr[OFFSET_W-1:0] & low_mask[OFFSET_W-1:0];
        push_valid  = s_tvalid;
        s_tready    = push_ready;
    end

endmodule

`default_nettype wire

@@ rtl/lfu_queue.sv @@
`default_nettype none

module lfu_queue
    import lfu_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push_valid,
    output logic          push_ready,
    input  wire lfu_req_t push_req,
    output logic          pop_valid,
    input  wire logic     pop_ready,
    output lfu_req_t      pop_req
);

    lfu_req_t                 mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_PTR_W:0]     count_reg;
    logic                     do_push;
    logic                     do_pop;

    always_comb
    begin
        push_ready = (count_reg != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
        pop_valid  = (count_reg != '0);
        pop_req    = mem[rd_ptr_reg];
        do_push    = push_valid && push_ready;
        do_pop     = pop_valid && pop_ready;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!do_push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/lfu_back.sv @@
`default_nettype none

module lfu_back
    import lfu_pkg::*;
#(
    parameter int NUM_WAYS   = 16,
    parameter int COUNT_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pop_valid,
    output logic                       pop_ready,
    input  wire lfu_req_t              pop_req,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    localparam int IDX_W      = $clog2(NUM_WAYS);
    localparam int GROUP_SIZE = (NUM_WAYS < 8) ? NUM_WAYS : 8;
    localparam int NUM_GROUPS = (NUM_WAYS + GROUP_SIZE - 1) / GROUP_SIZE;

    lfu_back_state_t          state_reg;
    lfu_back_state_t          state_next;

    logic [NUM_WAYS-1:0]      valid_reg;
    logic [ADDR_W-1:0]        addr_reg [NUM_WAYS];
    logic [COUNT_BITS-1:0]    cnt_reg  [NUM_WAYS];
    logic [TOTAL_W-1:0]       hits_reg;
    logic [TOTAL_W-1:0]       misses_reg;

    lfu_req_t                 req_reg;
    logic                     hit_reg;
    logic [IDX_W-1:0]         hit_idx_reg;
    logic [COUNT_BITS-1:0]    grp_cnt_reg [NUM_GROUPS];
    logic [IDX_W-1:0]         grp_idx_reg [NUM_GROUPS];

    logic                     hit_any;
    logic [IDX_W-1:0]         hit_idx;
    logic [COUNT_BITS-1:0]    grp_cnt [NUM_GROUPS];
    logic [IDX_W-1:0]         grp_idx [NUM_GROUPS];
    logic [COUNT_BITS-1:0]    victim_cnt;
    logic [IDX_W-1:0]         victim;
    logic [IDX_W-1:0]         way_idx;
    logic [WAY_W+IDX_W-1:0]   way_wide;
    logic [TOTAL_W-1:0]       hits_next;
    logic [TOTAL_W-1:0]       misses_next;
    logic                     out_free;
    logic                     commit;
    lfu_rsp_t                 rsp;
    logic                     m_tvalid_reg;
    logic [OUT_DATA_W-1:0]    m_tdata_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = NUM_WAYS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (addr_reg[i] == pop_req.line))
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_cnt[g] = cnt_reg[g*GROUP_SIZE];
            grp_idx[g] = IDX_W'(g*GROUP_SIZE);
            for (int k = 1; k < GROUP_SIZE; k++)
            begin
                if ((g*GROUP_SIZE + k < NUM_WAYS) &&
                    (cnt_reg[g*GROUP_SIZE + k] < grp_cnt[g]))
                begin
                    grp_cnt[g] = cnt_reg[g*GROUP_SIZE + k];
                    grp_idx[g] = IDX_W'(g*GROUP_SIZE + k);
                end
            end
        end
    end

    always_comb
    begin
        victim_cnt = grp_cnt_reg[0];
        victim     = grp_idx_reg[0];
        for (int g = 1; g < NUM_GROUPS; g++)
        begin
            if (grp_cnt_reg[g] < victim_cnt)
            begin
                victim_cnt = grp_cnt_reg[g];
                victim     = grp_idx_reg[g];
            end
        end
        way_idx     = hit_reg ? hit_idx_reg : victim;
        way_wide    = {{WAY_W{1'b0}}, way_idx};
        hits_next   = (hit_reg && (hits_reg != '1)) ? hits_reg + 1'b1 : hits_reg;
        misses_next = (!hit_reg && (misses_reg != '1)) ? misses_reg + 1'b1 : misses_reg;

        rsp.hit            = hit_reg;
        rsp.way            = way_wide[WAY_W-1:0];
        rsp.offset         = req_reg.offset;
        rsp.replaced_valid = !hit_reg && valid_reg[victim];
        rsp.hit_total      = hits_next;
        rsp.miss_total     = misses_next;
    end

    always_comb
    begin
        state_next = state_reg;
        pop_ready  = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            BACK_LOOKUP:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    state_next = BACK_UPDATE;
                end
            end
            BACK_UPDATE:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = BACK_LOOKUP;
                end
            end
            default:
            begin
                state_next = BACK_LOOKUP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BACK_LOOKUP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // stage the lookup results
    always_ff @(posedge clk)
    begin
        if (pop_ready && pop_valid)
        begin
            req_reg     <= pop_req;
            hit_reg     <= hit_any;
            hit_idx_reg <= hit_idx;
            grp_cnt_reg <= grp_cnt;
            grp_idx_reg <= grp_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && !hit_reg)
        begin
            addr_reg[victim] <= req_reg.line;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
            for (int i = 0; i < NUM_WAYS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (commit)
        begin
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
            if (hit_reg)
            begin
                if (cnt_reg[hit_idx_reg] != '1)
                begin
                    cnt_reg[hit_idx_reg] <= cnt_reg[hit_idx_reg] + 1'b1;
                end
            end
            else
            begin
                valid_reg[victim] <= 1'b1;
                cnt_reg[victim]   <= COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (commit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            m_tdata_reg <= OUT_DATA_W'(rsp);
        end
    end

endmodule

`default_nettype wire

@@ rtl/lfu_fully_associative_lookup_core.sv @@
`default_nettype none

// Channel   Dir  Beat contents (low bit first)
// s_axis    in   tdata: address[31:0]
// m_axis    out  tdata: hit, way[3:0], offset[5:0], replaced_valid,
//                hit_total[31:0], miss_total[31:0], 4 zero bits
// cfg       in   cfg_wdata: line_offset_bits[2:0], written when cfg_we is high
//
// The back end handles each beat in a lookup step (tag match and first level of the
// least-count search) and then an update step (final search step and way update),
// and takes no new beat until the update is done. A 2-entry queue sits before it.
// rst_n is asynchronous; valid bits, use counts and totals clear at once.
// A stalled output holds the back end in its update step; the queue keeps taking beats until full.

module lfu_fully_associative_lookup_core
    import lfu_pkg::*;
#(
    parameter int NUM_WAYS   = 16,
    parameter int COUNT_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_W-1:0]      cfg_wdata,   // line_offset_bits
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,     // address
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata      // hit, way, offset, replaced_valid,
                                                    // hit_total, miss_total
);

    logic     push_valid;
    logic     push_ready;
    lfu_req_t push_req;
    logic     pop_valid;
    logic     pop_ready;
    lfu_req_t pop_req;

    lfu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req)
    );

    lfu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_req    (pop_req)
    );

    lfu_back #(
        .NUM_WAYS   (NUM_WAYS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_req    (pop_req),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

@@ tb/lfu_lookup_checker.sv @@
module lfu_lookup_checker
    import lfu_pkg::*;
#(
    parameter int NUM_WAYS   = 16,
    parameter int COUNT_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    mismatch_count,
    output int                    outstanding,
    output int                    hit_beats,
    output int                    miss_beats,
    output int                    eviction_beats
);

    localparam int                    RSP_W     = $bits(lfu_rsp_t);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_W-1:0]    TOTAL_MAX = '1;
    localparam int                    PRINT_MAX = 50;

    logic                  way_valid [NUM_WAYS];
    logic [ADDR_W-1:0]     way_line  [NUM_WAYS];
    logic [COUNT_BITS-1:0] way_uses  [NUM_WAYS];
    logic [TOTAL_W-1:0]    hits_so_far;
    logic [TOTAL_W-1:0]    misses_so_far;
    logic [CFG_W-1:0]      line_bits;
    lfu_rsp_t              expected_rsps [$];

    function automatic void clear_model();
        int i;
        for (i = 0; i < NUM_WAYS; i++)
        begin
            way_valid[i] = 1'b0;
            way_line[i]  = '0;
            way_uses[i]  = '0;
        end
        hits_so_far    = '0;
        misses_so_far  = '0;
        line_bits      = CFG_W'(CFG_RESET);
        expected_rsps.delete();
        mismatch_count = 0;
        outstanding    = 0;
        hit_beats      = 0;
        miss_beats     = 0;
        eviction_beats = 0;
    endfunction

    // Look one address up and apply the LFU update it causes.
    function automatic lfu_rsp_t lookup_and_update(input logic [ADDR_W-1:0] addr);
        lfu_rsp_t              rsp;
        int unsigned           eff_bits;
        logic [ADDR_W-1:0]     low_mask;
        logic [ADDR_W-1:0]     line;
        int                    found_way;
        int                    victim;
        logic [COUNT_BITS-1:0] least;
        int                    i;
        eff_bits  = (line_bits > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : line_bits;
        low_mask  = (ADDR_W'(1) << eff_bits) - ADDR_W'(1);
        line      = addr & ~low_mask;
        found_way = -1;
        for (i = 0; i < NUM_WAYS; i++)
        begin
            if (found_way < 0 && way_valid[i] && way_line[i] == line)
                found_way = i;
        end
        rsp        = '0;
        rsp.offset = OFFSET_W'(addr & low_mask);
        if (found_way >= 0)
        begin
            rsp.hit = 1'b1;
            rsp.way = WAY_W'(found_way);
            if (hits_so_far != TOTAL_MAX)
                hits_so_far++;
            if (way_uses[found_way] != COUNT_MAX)
                way_uses[found_way]++;
            hit_beats++;
        end
        else
        begin
            victim = 0;
            least  = way_uses[0];
            for (i = 1; i < NUM_WAYS; i++)
            begin
                if (way_uses[i] < least)
                begin
                    least  = way_uses[i];
                    victim = i;
                end
            end
            if (misses_so_far != TOTAL_MAX)
                misses_so_far++;
            rsp.way            = WAY_W'(victim);
            rsp.replaced_valid = way_valid[victim];
            if (way_valid[victim])
                eviction_beats++;
            way_valid[victim] = 1'b1;
            way_line[victim]  = line;
            way_uses[victim]  = COUNT_BITS'(1);
            miss_beats++;
        end
        rsp.hit_total  = hits_so_far;
        rsp.miss_total = misses_so_far;
        return rsp;
    endfunction

    task automatic report_mismatch(input string what, input logic [TOTAL_W-1:0] got,
                                   input logic [TOTAL_W-1:0] want);
        if (mismatch_count < PRINT_MAX)
            $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result(input logic [OUT_DATA_W-1:0] beat);
        lfu_rsp_t got;
        lfu_rsp_t want;
        got = lfu_rsp_t'(beat[RSP_W-1:0]);
        if (expected_rsps.size() == 0)
        begin
            report_mismatch("result beat with none expected, low data", beat[TOTAL_W-1:0], '0);
            return;
        end
        want = expected_rsps.pop_front();
        if (got.hit !== want.hit)
            report_mismatch("hit", TOTAL_W'(got.hit), TOTAL_W'(want.hit));
        if (got.way !== want.way)
            report_mismatch("way", TOTAL_W'(got.way), TOTAL_W'(want.way));
        if (got.offset !== want.offset)
            report_mismatch("offset", TOTAL_W'(got.offset), TOTAL_W'(want.offset));
        if (got.replaced_valid !== want.replaced_valid)
            report_mismatch("replaced_valid", TOTAL_W'(got.replaced_valid),
                            TOTAL_W'(want.replaced_valid));
        if (got.hit_total !== want.hit_total)
            report_mismatch("hit_total", got.hit_total, want.hit_total);
        if (got.miss_total !== want.miss_total)
            report_mismatch("miss_total", got.miss_total, want.miss_total);
        if (beat[OUT_DATA_W-1:RSP_W] !== '0)
            report_mismatch("tdata padding", TOTAL_W'(beat[OUT_DATA_W-1:RSP_W]), '0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_model();
        end
        else
        begin
            if (cfg_we)
                line_bits = cfg_wdata;
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (s_tvalid && s_tready)
                expected_rsps.push_back(lookup_and_update(s_tdata));
            outstanding = expected_rsps.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    import lfu_pkg::*;

    localparam int NUM_WAYS    = 16;
    localparam int COUNT_BITS  = 16;
    localparam int POOL_SIZE   = 24;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 120;
    localparam int HOT_HITS    = 40;
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 120;
    localparam int HOLD_PERIOD = 2500;
    localparam logic [PHASES*CFG_W-1:0] PHASE_BITS =
        {3'd2, 3'd4, 3'd5, 3'd1, 3'd3, 3'd7, 3'd6, 3'd0};

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int                    mismatch_count;
    int                    outstanding;
    int                    hit_beats;
    int                    miss_beats;
    int                    eviction_beats;

    logic                  fast_mode    = 1'b0;
    int                    burst_left   = 0;
    int                    gap_left     = 0;
    int                    stall_cycles = 0;
    logic [CFG_W-1:0]      cur_bits     = CFG_W'(CFG_RESET);
    logic [ADDR_W-1:0]     line_pool [POOL_SIZE];

    lfu_fully_associative_lookup_core #(
        .NUM_WAYS   (NUM_WAYS),
        .COUNT_BITS (COUNT_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    lfu_lookup_checker #(
        .NUM_WAYS   (NUM_WAYS),
        .COUNT_BITS (COUNT_BITS)
    ) chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .hit_beats      (hit_beats),
        .miss_beats     (miss_beats),
        .eviction_beats (eviction_beats)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Offer one beat, possibly idling first when a new burst starts; returns at a falling edge.
    task automatic send_addr(input logic [ADDR_W-1:0] addr);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap_left   = (fast_mode || $urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
        end
        while (gap_left > 0)
        begin
            s_tvalid <= 1'b0;
            gap_left--;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    // Drain the block, then change the line size.
    task automatic write_line_bits(input logic [CFG_W-1:0] bits);
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= bits;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_bits   = bits;
    endtask

    function automatic logic [ADDR_W-1:0] pool_addr(input int idx);
        int unsigned       eff_bits;
        logic [ADDR_W-1:0] low_mask;
        eff_bits = (cur_bits > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : cur_bits;
        low_mask = (ADDR_W'(1) << eff_bits) - ADDR_W'(1);
        return (line_pool[idx] & ~low_mask) | (ADDR_W'($urandom) & low_mask);
    endfunction

    initial
    begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        int since_hold;
        mode       = 0;
        mode_left  = 0;
        hold_left  = 0;
        since_hold = HOLD_PERIOD - 300;
        forever
        begin
            @(negedge clk);
            if (fast_mode)
            begin
                m_tready <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (since_hold >= HOLD_PERIOD)
            begin
                hold_left  = LONG_HOLD - 1;
                since_hold = 0;
                m_tready  <= 1'b0;
            end
            else
            begin
                since_hold++;
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 5) == 0);
                    default: m_tready <= since_hold[0];
                endcase
            end
        end
    end

    initial
    begin : watchdog
        @(posedge rst_n);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        int phase;
        int n;
        for (i = 0; i < POOL_SIZE; i++)
            line_pool[i] = $urandom;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Extremes, same-line hits, fill all ways, then evict valid lines.
        send_addr(32'h0000_0000);
        send_addr(32'h0000_0003);
        send_addr(32'hFFFF_FFFF);
        send_addr(32'hFFFF_FFFC);
        send_addr(32'h0000_0004);
        for (i = 0; i < NUM_WAYS - 3; i++)
            send_addr(32'h1000_0000 + ADDR_W'(i * 4 + i % 4));
        send_addr(32'h5555_5555);
        send_addr(32'hAAAA_AAAA);
        send_addr(32'h0000_0004);
        send_addr(32'h0000_0002);

        // Hammer one line, then sweep new lines; the hot line must never become the victim.
        s_tvalid  <= 1'b0;
        burst_left = 0;
        fast_mode <= 1'b1;
        @(negedge clk);
        for (i = 0; i < HOT_HITS; i++)
            send_addr(ADDR_W'($urandom_range(0, 3)));
        for (i = 0; i < 2 * NUM_WAYS; i++)
            send_addr(32'h2000_0000 + ADDR_W'(i * 4));
        send_addr(32'h0000_0001);
        s_tvalid  <= 1'b0;
        burst_left = 0;
        fast_mode <= 1'b0;
        @(negedge clk);

        // Random traffic over a skewed line pool, one line size per phase.
        for (phase = 0; phase < PHASES; phase++)
        begin
            write_line_bits(PHASE_BITS[phase*CFG_W +: CFG_W]);
            for (n = 0; n < 6; n++)
                line_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 9) < 2)
                    send_addr($urandom);
                else
                    send_addr(pool_addr($urandom_range(0, $urandom_range(0, POOL_SIZE - 1))));
            end
        end

        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        $display("Run covered %0d lookups: %0d hits, %0d misses, %0d valid lines evicted",
                 hit_beats + miss_beats, hit_beats, miss_beats, eviction_beats);
        $display("Line sizes 1 to 64 words plus the out-of-range code; a hot way kept through a sweep");
        if (mismatch_count == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ lfu_fully_associative_lookup_core.f @@
rtl/lfu_pkg.sv
rtl/lfu_front.sv
rtl/lfu_queue.sv
rtl/lfu_back.sv
rtl/lfu_fully_associative_lookup_core.sv
tb/lfu_lookup_checker.sv
tb/tb_top.sv
